// ===== hdl/bpq_pkg.sv =====
// Shared types and constants for the bounded three-level priority queue.
package bpq_pkg;

   // Default sizes for the top-level parameters
   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed field widths of the channels
   localparam int ITEM_DATA_W = 32;
   localparam int LEVEL_W     = 2;
   localparam int COUNT_W     = 5;

   // Priority levels
   localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd2;

   typedef enum logic {
      OP_INSERT  = 1'b0,
      OP_EXTRACT = 1'b1
   } op_type;

   // Operation handed to the sorted store for one beat
   typedef struct packed {
      logic               fire;
      op_type             opcode;
      logic [LEVEL_W-1:0] level;
   } op_ctrl_type;

   // Status of that operation, returned by the sorted store
   typedef struct packed {
      logic               success;
      logic               dropped;
      logic [LEVEL_W-1:0] level;
      logic [COUNT_W-1:0] count;
   } op_status_type;

endpackage

// ===== hdl/bpq_if.sv =====
// Request and response channel interfaces of the priority queue.
interface bpq_req_if import bpq_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   opcode;
   logic [ITEM_DATA_W-1:0] item_data;
   logic [LEVEL_W-1:0]     item_priority;

   modport source (output valid, output opcode, output item_data, output item_priority,
                   input ready);
   modport sink   (input valid, input opcode, input item_data, input item_priority,
                   output ready);
endinterface

interface bpq_rsp_if import bpq_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   success;
   logic [ITEM_DATA_W-1:0] out_data;
   logic [LEVEL_W-1:0]     out_priority;
   logic                   dropped;
   logic [COUNT_W-1:0]     entry_count;

   modport source (output valid, output success, output out_data, output out_priority,
                   output dropped, output entry_count, input ready);
   modport sink   (input valid, input success, input out_data, input out_priority,
                   input dropped, input entry_count, output ready);
endinterface

// ===== hdl/bpq_sorted_store.sv =====
// Sorted register array: parallel compare for the insert point, then a shift of the entries.
module bpq_sorted_store import bpq_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  op_ctrl_type           ctrl,
   input  logic [DATA_WIDTH-1:0] word,
   output op_status_type         status,
   output logic [DATA_WIDTH-1:0] head_word
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CNT_KW = (CNT_W < COUNT_W) ? CNT_W : COUNT_W;

   logic [DATA_WIDTH-1:0] data_ff  [DEPTH];
   logic [DATA_WIDTH-1:0] data_in  [DEPTH];
   logic [LEVEL_W-1:0]    level_ff [DEPTH];
   logic [LEVEL_W-1:0]    level_in [DEPTH];
   logic [CNT_W-1:0]      occ_ff;
   logic [CNT_W-1:0]      occ_in;
   logic [CNT_W-1:0]      occ_base;
   logic [LEVEL_W-1:0]    lvl;
   logic [DEPTH-1:0]      keep;
   logic [DEPTH-1:0]      keep_prev;
   logic                  full;
   logic                  empty;
   logic                  is_insert;
   logic                  write_en;

   // Clamp level, trim a full queue by its tail, mark entries that stay put
   always_comb begin
      is_insert = (ctrl.opcode == OP_INSERT);
      lvl       = (ctrl.level > LEVEL_HIGH) ? LEVEL_HIGH : ctrl.level;
      full      = (occ_ff >= CNT_W'(DEPTH));
      empty     = (occ_ff == '0);
      occ_base  = full ? CNT_W'(DEPTH - 1) : occ_ff;
      for (int i = 0; i < DEPTH; i++) begin
         keep[i] = (CNT_W'(i) < occ_base) && (level_ff[i] >= lvl);
      end
      keep_prev = {keep[DEPTH-2:0], 1'b1};
   end

   // Next array contents: insert shifts the tail down, extract shifts up
   always_comb begin
      if (is_insert) begin
         data_in[0]  = keep[0] ? data_ff[0] : word;
         level_in[0] = keep[0] ? level_ff[0] : lvl;
         for (int i = 1; i < DEPTH; i++) begin
            if (keep[i]) begin
               data_in[i]  = data_ff[i];
               level_in[i] = level_ff[i];
            end else if (keep_prev[i]) begin
               data_in[i]  = word;
               level_in[i] = lvl;
            end else begin
               data_in[i]  = data_ff[i-1];
               level_in[i] = level_ff[i-1];
            end
         end
      end else begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            data_in[i]  = data_ff[i+1];
            level_in[i] = level_ff[i+1];
         end
         data_in[DEPTH-1]  = data_ff[DEPTH-1];
         level_in[DEPTH-1] = level_ff[DEPTH-1];
      end
   end

   // Occupancy and result status
   always_comb begin
      write_en = ctrl.fire && (is_insert || !empty);
      if (is_insert) begin
         occ_in = occ_base + 1'b1;
      end else if (empty) begin
         occ_in = occ_ff;
      end else begin
         occ_in = occ_ff - 1'b1;
      end
      status         = '0;
      status.success = is_insert || !empty;
      status.dropped = is_insert && full;
      status.count[CNT_KW-1:0] = occ_in[CNT_KW-1:0];
      head_word      = '0;
      if (!is_insert && !empty) begin
         status.level = level_ff[0];
         head_word    = data_ff[0];
      end
   end

   // Entry storage, no reset: only entries below the count are ever read
   always_ff @(posedge clock) begin
      if (write_en) begin
         data_ff  <= data_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (ctrl.fire) begin
         occ_ff <= occ_in;
      end
   end

   // Count never passes the capacity
   assert property (@(posedge clock) disable iff (reset) occ_ff <= CNT_W'(DEPTH))
      else $error("bpq: occupancy above depth");

   // Insert grows the count unless full, where it stays at capacity
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.fire && ctrl.opcode == OP_INSERT) |=>
         (occ_ff == CNT_W'(DEPTH)) ||
         (occ_ff == CNT_W'($past(occ_ff) + 1'b1)))
      else $error("bpq: insert count update wrong");

   // Extract on a non-empty queue drops the count by one
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.fire && ctrl.opcode == OP_EXTRACT && occ_ff != '0) |=>
         (occ_ff == CNT_W'($past(occ_ff) - 1'b1)))
      else $error("bpq: extract count update wrong");

   // An extract that finds the queue empty reports failure
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.opcode == OP_EXTRACT && occ_ff == '0) |-> !status.success)
      else $error("bpq: empty extract reported success");

endmodule

// ===== hdl/bounded_three_level_priority_queue_core.sv =====
// A request beat passes the request register, then the response register, before
// its response beat can be accepted.
// Throughput: one operation per cycle unless the response channel stalls; the sorted
// register array inserts or extracts between the request and response registers.
// Backpressure on the response channel stalls the request register, which then holds off requests.
// Reset (synchronous) empties the queue and clears both registers' valid flags;
// entry contents are not cleared.
module bounded_three_level_priority_queue_core import bpq_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bpq_req_if.sink   req_chan,
   bpq_rsp_if.source rsp_chan
);

   localparam int KEEP_W = (DATA_WIDTH < ITEM_DATA_W) ? DATA_WIDTH : ITEM_DATA_W;

   logic                   in_valid_ff;
   logic                   in_op_ff;
   logic [ITEM_DATA_W-1:0] in_data_ff;
   logic [LEVEL_W-1:0]     in_level_ff;
   logic                   out_valid_ff;
   op_status_type          out_status_ff;
   logic [ITEM_DATA_W-1:0] out_data_ff;
   logic                   fire;
   op_ctrl_type            ctrl;
   op_status_type          status;
   logic [DATA_WIDTH-1:0]  word;
   logic [DATA_WIDTH-1:0]  head_word;
   logic [ITEM_DATA_W-1:0] head_wide;

   // Request register moves on when the response register is free
   always_comb begin
      fire           = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
      req_chan.ready = !in_valid_ff || fire;
      ctrl.fire      = fire;
      ctrl.opcode    = op_type'(in_op_ff);
      ctrl.level     = in_level_ff;
      word           = '0;
      word[KEEP_W-1:0]      = in_data_ff[KEEP_W-1:0];
      head_wide             = '0;
      head_wide[KEEP_W-1:0] = head_word[KEEP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_op_ff    <= req_chan.opcode;
         in_data_ff  <= req_chan.item_data;
         in_level_ff <= req_chan.item_priority;
      end
   end

   bpq_sorted_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .word      (word),
      .status    (status),
      .head_word (head_word)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_status_ff <= status;
         out_data_ff   <= head_wide;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.success      = out_status_ff.success;
   assign rsp_chan.out_data     = out_data_ff;
   assign rsp_chan.out_priority = out_status_ff.level;
   assign rsp_chan.dropped      = out_status_ff.dropped;
   assign rsp_chan.entry_count  = out_status_ff.count;

   // Every operation taken into the store shows up as a response beat
   assert property (@(posedge clock) disable iff (reset) fire |=> out_valid_ff)
      else $error("bpq: response lost");

   // A waiting response is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |-> !fire)
      else $error("bpq: response overwritten");

   // A failed extract never carries a data word
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_status_ff.success) |-> (out_data_ff == '0))
      else $error("bpq: failed extract returned data");

endmodule
